FILE: hdl/pid_position_incremental_controller_macros.svh
// ----------------------------------------------------------------------------
// pid controller assertion macros
// shared implication checks for the controller and its serial multiplier
// ----------------------------------------------------------------------------
`ifndef PID_POSITION_INCREMENTAL_CONTROLLER_MACROS_SVH
`define PID_POSITION_INCREMENTAL_CONTROLLER_MACROS_SVH

// same-cycle implication
`define PIDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// shared types, constants and saturation helpers of the pid controller
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned IntegW = 48;
  localparam int unsigned McandW = 48;
  localparam int unsigned MplierW = 33;
  localparam int unsigned ProdW = McandW + MplierW + 1;
  localparam int unsigned SumW = 68;
  localparam int unsigned CntW = 6;

  localparam logic signed [31:0] PosLimit = 32'sd4587520;
  localparam logic signed [31:0] IncLimit = 32'sd3932160;
  localparam logic [16:0] AlphaOne = 17'd65536;

  localparam logic [2:0] RegMode = 3'd0;
  localparam logic [2:0] RegSetpoint = 3'd1;
  localparam logic [2:0] RegGainP = 3'd2;
  localparam logic [2:0] RegGainI = 3'd3;
  localparam logic [2:0] RegGainD = 3'd4;
  localparam logic [2:0] RegFilter = 3'd5;
  localparam logic [2:0] RegUpper = 3'd6;
  localparam logic [2:0] RegLower = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_UPD, S_MUL_P, S_MUL_I, S_MUL_T, S_MUL_F, S_MUL_A,
    S_SUM, S_CLAMP, S_DONE
  } state_e;

  typedef struct packed {
    logic                      start;
    logic signed [McandW-1:0]  mcand;
    logic signed [MplierW-1:0] mplier;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32'sh7fffffff);
    lo = -SumW'(33'sh080000000);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    if (v > 50'sh07fffffffffff) return 48'sh7fffffffffff;
    else if (v < -50'sh00800000000000) return 48'sh800000000000;
    else return v[47:0];
  endfunction

endpackage

FILE: hdl/pidc_smul.sv
// ----------------------------------------------------------------------------
// pidc_smul
// bit-serial signed shift-and-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module pidc_smul import pidc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mul_req_t                mul_req_i,
  output logic                    done_o,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0]   acc_q, mc_q, addend;
  logic signed [MplierW-1:0] mp_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q, done_q;

  assign addend = mp_q[0] ? mc_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (mul_req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MplierW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_req_i.start) begin
      acc_q <= '0;
      mc_q  <= ProdW'(mul_req_i.mcand);
      mp_q  <= mul_req_i.mplier;
    end else if (busy_q) begin
      // sign bit of the multiplier carries negative weight
      acc_q <= (cnt_q == CntW'(MplierW - 1)) ? acc_q - addend : acc_q + addend;
      mc_q  <= mc_q <<< 1;
      mp_q  <= mp_q >>> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

`include "pid_position_incremental_controller_macros.svh"

  `PIDC_ASSERT_NXT(a_start_busy, mul_req_i.start, busy_q && !done_q, "start did not begin")
  `PIDC_ASSERT_IMP(a_done_idle, done_q, !busy_q, "done while busy")
  `PIDC_ASSERT_IMP(a_cnt_range, busy_q, cnt_q < CntW'(MplierW), "step count overrun")

endmodule

FILE: hdl/pid_position_incremental_controller.sv
// ----------------------------------------------------------------------------
// pid_position_incremental_controller
// pid controller, positional or incremental, with integral separation,
// filtered derivative and output clamp; products formed bit-serially
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o | measurement_i
// out     | output    | out_valid_o/out_stall_i | drive_o, clamped_o
// cfg     | input     | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// a request passes from accept to result through error, update, five products
// through the one serial multiplier, sum, clamp and hand-off; the next request
// is taken once the controller is back in idle after the hand-off
// one request is in work at a time; the next is taken while a result waits
// reset is asynchronous, active low, and needs no clearing pass
// a stalled result holds its output register; work stops before hand-off
// ----------------------------------------------------------------------------
module pid_position_incremental_controller import pidc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] measurement_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] drive_o,
  output logic               clamped_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  logic               mode_q;
  logic signed [31:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q, upper_q, lower_q;
  logic [16:0]        filter_q;

  logic signed [31:0] err_prev_q, err_prev2_q, deriv_prev_q, out_acc_q;
  logic signed [47:0] integ_q;

  logic signed [31:0] meas_q, e_q, delta_q, x_q, t_q, d_q;
  logic signed [SumW-1:0] p_q, i_q, f_q, r_q;
  logic signed [31:0] res_drive_q;
  logic               res_hit_q;
  logic               out_valid_q, out_clamped_q;
  logic signed [31:0] out_drive_q;

  mul_req_t               mul_req;
  logic                   mul_done;
  logic signed [ProdW-1:0] prod;
  logic signed [SumW-1:0]  prod_sh;

  logic [16:0] alpha, alpha_c;
  logic signed [32:0] half;
  logic signed [34:0] delta_inc;
  logic signed [SumW-1:0] sum_r, upper_x, lower_x;
  logic in_acc, out_free;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign alpha    = (filter_q > AlphaOne) ? AlphaOne : filter_q;
  assign alpha_c  = AlphaOne - alpha;
  assign prod_sh  = SumW'(signed'(prod[ProdW-1:16]));
  assign half     = 33'((34'(e_q) + 34'(err_prev_q)) >>> 1);
  assign delta_inc = 35'(e_q) - (35'(err_prev_q) <<< 1) + 35'(err_prev2_q);
  assign sum_r    = p_q + i_q + SumW'(d_q) + (mode_q ? SumW'(out_acc_q) : '0);
  assign upper_x  = SumW'(upper_q);
  assign lower_x  = SumW'(lower_q);

  pidc_smul u_smul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mul_req_i (mul_req),
    .done_o    (mul_done),
    .prod_o    (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      issued_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    mul_req  = '{start: 1'b0, mcand: '0, mplier: '0};
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ERR;
      S_ERR:   state_d = S_UPD;
      S_UPD:   state_d = S_MUL_P;
      S_MUL_P, S_MUL_I, S_MUL_T, S_MUL_F, S_MUL_A: begin
        case (state_q)
          S_MUL_P: begin
            mul_req.mcand = McandW'(x_q);
            mul_req.mplier = MplierW'(gain_p_q);
          end
          S_MUL_I: begin
            mul_req.mcand = integ_q;
            mul_req.mplier = MplierW'(gain_i_q);
          end
          S_MUL_T: begin
            mul_req.mcand = McandW'(delta_q);
            mul_req.mplier = MplierW'(gain_d_q);
          end
          S_MUL_F: begin
            mul_req.mcand = McandW'(t_q);
            mul_req.mplier = MplierW'({1'b0, alpha_c});
          end
          default: begin
            mul_req.mcand = McandW'(deriv_prev_q);
            mul_req.mplier = MplierW'({1'b0, alpha});
          end
        endcase
        if (!issued_q) begin
          mul_req.start = 1'b1;
          issued_d = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          case (state_q)
            S_MUL_P: state_d = S_MUL_I;
            S_MUL_I: state_d = S_MUL_T;
            S_MUL_T: state_d = S_MUL_F;
            S_MUL_F: state_d = S_MUL_A;
            default: state_d = S_SUM;
          endcase
        end
      end
      S_SUM:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      setpoint_q <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      filter_q   <= 17'd6554;
      upper_q    <= 32'sd11796480;
      lower_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:     mode_q     <= cfg_wdata_i[0];
        RegSetpoint: setpoint_q <= cfg_wdata_i;
        RegGainP:    gain_p_q   <= cfg_wdata_i;
        RegGainI:    gain_i_q   <= cfg_wdata_i;
        RegGainD:    gain_d_q   <= cfg_wdata_i;
        RegFilter:   filter_q   <= cfg_wdata_i[16:0];
        RegUpper:    upper_q    <= cfg_wdata_i;
        RegLower:    lower_q    <= cfg_wdata_i;
        default:     mode_q     <= mode_q;
      endcase
    end
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_prev_q   <= '0;
      err_prev2_q  <= '0;
      integ_q      <= '0;
      deriv_prev_q <= '0;
      out_acc_q    <= '0;
    end else begin
      if (state_q == S_UPD) begin
        if (!mode_q && e_q <= PosLimit) integ_q <= sat48(50'(integ_q) + 50'(half));
        else if (mode_q && e_q < IncLimit) integ_q <= 48'(e_q);
      end
      if (state_q == S_DONE && out_free) begin
        if (mode_q) err_prev2_q <= err_prev_q;
        err_prev_q   <= e_q;
        deriv_prev_q <= d_q;
        out_acc_q    <= res_drive_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_acc) meas_q <= measurement_i;
      S_ERR:  e_q <= sat32(SumW'(setpoint_q) - SumW'(meas_q));
      S_UPD: begin
        if (mode_q) begin
          delta_q <= sat32(SumW'(delta_inc));
          x_q     <= sat32(SumW'(e_q) - SumW'(err_prev_q));
        end else begin
          delta_q <= sat32(SumW'(e_q) - SumW'(err_prev_q));
          x_q     <= e_q;
        end
      end
      S_MUL_P: if (mul_done) p_q <= prod_sh;
      S_MUL_I: if (mul_done) i_q <= prod_sh;
      S_MUL_T: if (mul_done) t_q <= sat32(prod_sh);
      S_MUL_F: if (mul_done) f_q <= prod_sh;
      S_MUL_A: if (mul_done) d_q <= sat32(f_q + prod_sh);
      S_SUM:  r_q <= sum_r;
      S_CLAMP: begin
        // lower limit applied last wins on crossed limits
        if (r_q > upper_x) begin
          res_drive_q <= (upper_x < lower_x) ? lower_q : upper_q;
          res_hit_q   <= 1'b1;
        end else if (r_q < lower_x) begin
          res_drive_q <= lower_q;
          res_hit_q   <= 1'b1;
        end else begin
          res_drive_q <= r_q[31:0];
          res_hit_q   <= 1'b0;
        end
      end
      default: res_hit_q <= res_hit_q;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_drive_q   <= res_drive_q;
      out_clamped_q <= res_hit_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = out_drive_q;
  assign clamped_o   = out_clamped_q;

`include "pid_position_incremental_controller_macros.svh"

  `PIDC_ASSERT_NXT(a_acc_err, in_acc, state_q == S_ERR, "request did not start")
  `PIDC_ASSERT_IMP(a_load_done, $rose(out_valid_q), $past(state_q) == S_DONE, "stray result")
  `PIDC_ASSERT_IMP(a_mul_state, mul_done, state_q == S_MUL_P || state_q == S_MUL_I || state_q == S_MUL_T || state_q == S_MUL_F || state_q == S_MUL_A, "product outside multiply step")

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// pid controller testbench: a queue-fed driver offers measurement requests
// with random gaps, a receiver stalls at random and once for a long stretch,
// and a monitor checks each drive value and clamp flag against an in-bench
// fixed-point model of the controller, across directed and random settings
// ----------------------------------------------------------------------------
module tb_top;
  import pidc_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct {
    logic signed [31:0] drive;
    logic               clamped;
  } drive_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] measurement_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] drive_o;
  logic               clamped_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [31:0]        cfg_wdata_i;

  pid_position_incremental_controller u_dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // controller shadow: settings and loop state
  logic  ctl_mode;
  wide_t ctl_setpoint, ctl_kp, ctl_ki, ctl_kd, ctl_alpha, ctl_upper, ctl_lower;
  wide_t st_err1, st_err2, st_integ, st_deriv, st_out;

  logic signed [31:0] meas_q[$];
  drive_res_t         drive_q[$];
  int unsigned        mismatches;
  int unsigned        results_seen;
  int unsigned        clamp_hits;
  int unsigned        cycles;
  logic               no_idle;
  int unsigned        hold_seq;
  int unsigned        hold_seen;
  int unsigned        hold_left;
  int unsigned        send_gap;
  int unsigned        stall_left;
  logic               req_taken;

  function automatic wide_t clip(wide_t x, int w);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -(wide_t'(1) <<< (w - 1));
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  task automatic predict_drive(logic signed [31:0] meas);
    wide_t e, a, dlt, t, d, p, r;
    drive_res_t res;
    e = clip(ctl_setpoint - wide_t'(meas), 32);
    a = ctl_alpha > 65536 ? wide_t'(65536) : ctl_alpha;
    if (!ctl_mode) begin
      if (e <= wide_t'(PosLimit)) st_integ = clip(st_integ + ((e + st_err1) >>> 1), 48);
      dlt = clip(e - st_err1, 32);
      p = (ctl_kp * e) >>> 16;
    end else begin
      if (e < wide_t'(IncLimit)) st_integ = e;
      dlt = clip(e - 2 * st_err1 + st_err2, 32);
      p = (ctl_kp * clip(e - st_err1, 32)) >>> 16;
    end
    t = clip((ctl_kd * dlt) >>> 16, 32);
    d = clip(((t * (65536 - a)) >>> 16) + ((a * st_deriv) >>> 16), 32);
    r = p + ((ctl_ki * st_integ) >>> 16) + d;
    if (ctl_mode) r = r + st_out;
    res.clamped = 1'b0;
    if (r > ctl_upper) begin
      r = ctl_upper;
      res.clamped = 1'b1;
    end
    if (r < ctl_lower) begin
      r = ctl_lower;
      res.clamped = 1'b1;
    end
    if (ctl_mode) st_err2 = st_err1;
    st_err1 = e;
    st_deriv = d;
    st_out = r;
    res.drive = r[31:0];
    drive_q.push_back(res);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegMode:     ctl_mode = val[0];
      RegSetpoint: ctl_setpoint = wide_t'(signed'(val));
      RegGainP:    ctl_kp = wide_t'(signed'(val));
      RegGainI:    ctl_ki = wide_t'(signed'(val));
      RegGainD:    ctl_kd = wide_t'(signed'(val));
      RegFilter:   ctl_alpha = wide_t'({1'b0, val[16:0]});
      RegUpper:    ctl_upper = wide_t'(signed'(val));
      default:     ctl_lower = wide_t'(signed'(val));
    endcase
  endtask

  task automatic load_settings(logic md, logic [31:0] sp, logic [31:0] kp, logic [31:0] ki,
                               logic [31:0] kd, logic [31:0] fw, logic [31:0] up,
                               logic [31:0] lo);
    write_reg(RegMode, {31'b0, md});
    write_reg(RegSetpoint, sp);
    write_reg(RegGainP, kp);
    write_reg(RegGainI, ki);
    write_reg(RegGainD, kd);
    write_reg(RegFilter, fw);
    write_reg(RegUpper, up);
    write_reg(RegLower, lo);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    wait (meas_q.size() == 0 && !in_valid_i && drive_q.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2:       return 32'h0;
      default: return $urandom_range(0, 8 << 16) - (4 << 16);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (no_idle || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // request driver
  always @(negedge clk_i) begin
    logic nxt_valid;
    nxt_valid = 1'b0;
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (in_valid_i && !req_taken) begin
      nxt_valid = 1'b1;
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
    end else if (meas_q.size() > 0) begin
      measurement_i <= meas_q.pop_front();
      nxt_valid = 1'b1;
      send_gap <= pick_gap();
    end
    in_valid_i <= nxt_valid;
  end

  // result receiver stalls
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 3000;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      stall_left <= pick_gap();
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // request capture, result monitor, timeout
  always @(posedge clk_i) begin
    drive_res_t want;
    req_taken <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) predict_drive(measurement_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (clamped_o) clamp_hits++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result drive=%0d clamped=%0b",
                                       drive_o, clamped_o);
      end else begin
        want = drive_q.pop_front();
        if (drive_o !== want.drive || clamped_o !== want.clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: drive exp %0d got %0d, clamped exp %0b got %0b",
                     want.drive, drive_o, want.clamped, clamped_o);
        end
      end
    end
    cycles++;
    if (cycles > 2000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] m;
    logic [31:0] sp, up, lo;
    int unsigned n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    measurement_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    mismatches = 0;
    results_seen = 0;
    clamp_hits = 0;
    cycles = 0;
    no_idle = 1'b0;
    hold_seq = 0;
    hold_seen = 0;
    hold_left = 0;
    send_gap = 0;
    stall_left = 0;
    req_taken = 1'b0;
    ctl_mode = 1'b0;
    ctl_setpoint = 0;
    ctl_kp = 0;
    ctl_ki = 0;
    ctl_kd = 0;
    ctl_alpha = 6554;
    ctl_upper = 11796480;
    ctl_lower = 0;
    st_err1 = 0;
    st_err2 = 0;
    st_integ = 0;
    st_deriv = 0;
    st_out = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, then positional form around the separation threshold
    meas_q = '{32'sd0, 32'sd1 <<< 16, -32'sd1};
    drain();
    load_settings(1'b0, 32'h0, 32'h10000, 32'h1000, 32'h8000, 32'd6554,
                  32'h00b40000, 32'hff4c0000);
    meas_q = '{32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd1,
               -(32'sd70 <<< 16), -(32'sd70 <<< 16) - 1, -(32'sd60 <<< 16)};
    drain();
    // incremental form, full-scale gains, alpha above one, error overflow
    load_settings(1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h1ffff, 32'h7fffffff, 32'h80000000);
    meas_q = '{32'sh80000000, 32'sh7fffffff, 32'sd0, 32'sh80000000};
    drain();
    // incremental threshold, alpha exactly one, crossed limits
    load_settings(1'b1, 32'h0, 32'h20000, 32'hffff8000, 32'h10000, 32'd65536,
                  32'hfffffffb, 32'd5);
    meas_q = '{-(32'sd60 <<< 16), -(32'sd60 <<< 16) + 1, -(32'sd60 <<< 16) - 1,
               32'sd12345};
    drain();
    // back to positional with state carried over, alpha zero
    load_settings(1'b0, 32'h00100000, 32'h8000, 32'h4000, 32'h30000, 32'd0,
                  32'h00200000, 32'hffe00000);
    meas_q = '{32'sh00100000, 32'sh00000000, 32'sh7fffffff};
    drain();

    for (int ph = 0; ph < 20; ph++) begin
      sp = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 400 << 16) - (200 << 16);
      case ($urandom_range(0, 5))
        0: begin
          up = 32'h7fffffff;
          lo = 32'h80000000;
        end
        1: begin
          up = $urandom();
          lo = $urandom();
        end
        default: begin
          up = $urandom_range(0, 300 << 16);
          lo = -$urandom_range(0, 300 << 16);
        end
      endcase
      case ($urandom_range(0, 4))
        0: n = 0;
        1: n = 65536;
        2: n = $urandom_range(65537, 131071);
        default: n = $urandom_range(0, 65536);
      endcase
      load_settings(ph == 19 ? 1'b1 : 1'($urandom_range(0, 1)), sp, pick_gain(), pick_gain(),
                    pick_gain(), n, up, lo);
      no_idle = (ph % 7 == 3);
      for (int i = 0; i < 70; i++) begin
        if ($urandom_range(0, 4) == 0) m = $urandom();
        else m = sp - ($urandom_range(0, 160 << 16) - (80 << 16));
        meas_q.push_back(m);
      end
      if (ph == 5) hold_seq++;
      drain();
    end
    no_idle = 1'b0;

    $display("covered %0d drive results, %0d of them clamped, in both forms",
             results_seen, clamp_hits);
    $display("settings swept gains, alpha limits, setpoints and crossed clamps");
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, drive_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
